[rtl/actuator_torque_thermal_model_macros.svh]
// Assertion macros used by the checker file.
`ifndef ACTUATOR_TORQUE_THERMAL_MODEL_MACROS_SVH
`define ACTUATOR_TORQUE_THERMAL_MODEL_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ATTM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ATTM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/attm_pkg.sv]
`default_nettype none
package attm_pkg;
    localparam int NumRegs = 7;
    localparam logic signed [63:0] QOne = 64'sd65536;
    localparam logic signed [63:0] S32Max = 64'sd2147483647;
    localparam logic signed [63:0] S32Min = -64'sd2147483648;
    localparam logic signed [31:0] TempReset = 32'sd1638400;

    localparam logic [2:0] RegTorqueConst = 3'd0;
    localparam logic [2:0] RegThermalRef = 3'd1;
    localparam logic [2:0] RegElectrical = 3'd2;
    localparam logic [2:0] RegSupply = 3'd3;
    localparam logic [2:0] RegDryFriction = 3'd4;
    localparam logic [2:0] RegStribeckShape = 3'd5;
    localparam logic [2:0] RegLoss = 3'd6;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'(S32Max)) begin
            r = 32'sh7fffffff;
        end else if (v < 66'(S32Min)) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [15:0] exp_int(input logic [3:0] n);
        logic [15:0] r;
        case (n)
            4'd0: r = 16'd0;
            4'd1: r = 16'd24109;
            4'd2: r = 16'd8869;
            4'd3: r = 16'd3263;
            4'd4: r = 16'd1200;
            4'd5: r = 16'd442;
            4'd6: r = 16'd162;
            4'd7: r = 16'd60;
            4'd8: r = 16'd22;
            4'd9: r = 16'd8;
            4'd10: r = 16'd3;
            4'd11: r = 16'd1;
            default: r = 16'd0;
        endcase
        return r;
    endfunction

    function automatic logic [15:0] exp_frac(input logic [3:0] k);
        logic [15:0] r;
        case (k)
            4'd0: r = 16'd0;
            4'd1: r = 16'd61565;
            4'd2: r = 16'd57835;
            4'd3: r = 16'd54331;
            4'd4: r = 16'd51039;
            4'd5: r = 16'd47947;
            4'd6: r = 16'd45042;
            4'd7: r = 16'd42313;
            4'd8: r = 16'd39750;
            4'd9: r = 16'd37341;
            4'd10: r = 16'd35079;
            4'd11: r = 16'd32954;
            4'd12: r = 16'd30957;
            4'd13: r = 16'd29081;
            4'd14: r = 16'd27319;
            default: r = 16'd25664;
        endcase
        return r;
    endfunction

    // Table entry zero (65536) does not fit 16 bits and is marked by zero.
    function automatic logic signed [31:0] exp_int_q(input logic [3:0] n);
        return (n == 4'd0) ? 32'sd65536 : $signed({16'd0, exp_int(n)});
    endfunction

    function automatic logic signed [31:0] exp_frac_q(input logic [3:0] k);
        return (k == 4'd0) ? 32'sd65536 : $signed({16'd0, exp_frac(k)});
    endfunction

    typedef enum logic [3:0] {
        OP_MUL = 4'b0001,
        OP_DIV = 4'b0010,
        OP_ADD = 4'b0100,
        OP_SUB = 4'b1000
    } attm_op_t;

    typedef struct packed {
        logic start;
        attm_op_t op;
        logic signed [31:0] a;
        logic signed [31:0] b;
    } attm_req_t;

    typedef struct packed {
        logic done;
        logic signed [31:0] y;
    } attm_rsp_t;
endpackage
`default_nettype wire

[rtl/attm_alu.sv]
`default_nettype none
// Shared Q16.16 unit: registered multiply, add and subtract, or a restoring divide of one quotient bit per cycle.
module attm_alu (
    input wire logic aclk,
    input wire logic aresetn,
    input wire attm_pkg::attm_req_t req,
    output attm_pkg::attm_rsp_t rsp
);
    logic busy_reg, busy_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [63:0] num_reg, num_next;
    logic [31:0] den_reg, den_next;
    logic [48:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic neg_reg, neg_next;
    logic done_reg, done_next;
    logic signed [31:0] y_reg, y_next;
    logic signed [63:0] prod;
    logic signed [65:0] prod_r;
    logic signed [65:0] sum;
    logic signed [65:0] diff;
    logic [32:0] trial;
    logic [63:0] abs_a;
    logic signed [65:0] q_s;

    always_comb begin
        prod = 64'(req.a) * 64'(req.b);
        prod_r = (66'(prod) + 66'sd32768) >>> 16;
        sum = 66'(req.a) + 66'(req.b);
        diff = 66'(req.a) - 66'(req.b);
        abs_a = req.a[31] ? 64'(-65'(req.a)) : 64'($unsigned(req.a));
        trial = {rem_reg[31:0], num_reg[63]} - {1'b0, den_reg};
        q_s = neg_reg ? -$signed({17'd0, quo_reg}) : $signed({17'd0, quo_reg});
        busy_next = busy_reg;
        cnt_next = cnt_reg;
        num_next = num_reg;
        den_next = den_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        neg_next = neg_reg;
        done_next = 1'b0;
        y_next = y_reg;
        if (busy_reg) begin
            num_next = {num_reg[62:0], 1'b0};
            if (!trial[32]) begin
                rem_next = trial;
                quo_next = {quo_reg[47:0], 1'b1};
            end else begin
                rem_next = {rem_reg[31:0], num_reg[63]};
                quo_next = {quo_reg[47:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                y_next = attm_pkg::sat32(q_s);
            end
        end else if (req.start) begin
            case (req.op)
                attm_pkg::OP_MUL: begin
                    y_next = attm_pkg::sat32(prod_r);
                    done_next = 1'b1;
                end
                attm_pkg::OP_ADD: begin
                    y_next = attm_pkg::sat32(sum);
                    done_next = 1'b1;
                end
                attm_pkg::OP_SUB: begin
                    y_next = attm_pkg::sat32(diff);
                    done_next = 1'b1;
                end
                attm_pkg::OP_DIV: begin
                    busy_next = 1'b1;
                    cnt_next = 6'd48;
                    num_next = abs_a << 16 << 16;
                    den_next = req.b;
                    quo_next = '0;
                    rem_next = '0;
                    neg_next = req.a[31];
                end
                default: begin
                    done_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
        num_reg <= num_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
        y_reg <= y_next;
    end

    assign rsp.done = done_reg;
    assign rsp.y = y_reg;
endmodule
`default_nettype wire

[rtl/attm_seq.sv]
`default_nettype none
module attm_seq (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic go,
    input wire logic [63:0] regs [attm_pkg::NumRegs],
    input wire logic signed [31:0] cmd,
    input wire logic signed [31:0] spd,
    input wire logic signed [31:0] cur,
    input wire logic [30:0] dt,
    input wire logic signed [31:0] amb,
    output attm_pkg::attm_req_t req,
    input wire attm_pkg::attm_rsp_t rsp,
    output logic fin,
    output logic signed [31:0] o_t,
    output logic [30:0] o_ceil,
    output logic signed [31:0] o_fr,
    output logic signed [31:0] o_temp
);
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_ISSUE = 3'b010,
        ST_WAIT = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic [5:0] step_reg, step_next;
    logic signed [31:0] temp_reg, temp_next;
    logic signed [31:0] v_reg [16];
    logic signed [31:0] opa, opb;
    attm_pkg::attm_op_t op;
    logic last;
    logic signed [31:0] kt, kco, cal, mass, res, ksp, vb, imx, cou, stb, vs, asy, vis, cnd;
    logic signed [31:0] absv, x, poly, rr;
    logic [3:0] wr_idx;
    logic signed [31:0] wr_val;

    assign kt = regs[0][63:32];
    assign kco = regs[0][31:0];
    assign cal = regs[1][63:32];
    assign mass = regs[1][31:0];
    assign res = regs[2][63:32];
    assign ksp = regs[2][31:0];
    assign vb = regs[3][63:32];
    assign imx = regs[3][31:0];
    assign cou = regs[4][63:32];
    assign stb = regs[4][31:0];
    assign vs = regs[5][63:32];
    assign asy = regs[5][31:0];
    assign vis = regs[6][63:32];
    assign cnd = regs[6][31:0];

    always_comb begin
        absv = (spd == 32'sh80000000) ? 32'sh7fffffff : (spd[31] ? -spd : spd);
        x = v_reg[8];
        rr = $signed({20'd0, x[11:0]});
        poly = 32'sd65536 - rr + (v_reg[10] >>> 1);
    end

    // Step program: each step is one operation of the shared unit.
    always_comb begin
        op = attm_pkg::OP_MUL;
        opa = '0;
        opb = '0;
        last = 1'b0;
        case (step_reg)
            6'd0: begin op = attm_pkg::OP_SUB; opa = temp_reg; opb = cal; end
            6'd1: begin opa = kco; opb = v_reg[0]; end
            6'd2: begin op = attm_pkg::OP_SUB; opa = 32'sd65536; opb = v_reg[0]; end
            6'd3: begin opa = kt; opb = v_reg[0][31] ? 32'sd0 : v_reg[0]; end
            6'd4: begin op = attm_pkg::OP_DIV; opa = 32'sd65536;
                opb = (ksp > 0) ? ksp : 32'sd1; end
            6'd5: begin opa = (ksp > 0) ? v_reg[2] : 32'sd0; opb = absv; end
            6'd6: begin op = attm_pkg::OP_ADD; opa = vb; opb = -v_reg[2]; end
            6'd7: begin op = attm_pkg::OP_DIV; opa = v_reg[2];
                opb = (res > 0) ? res : 32'sd1; end
            6'd8: begin opa = v_reg[1];
                opb = (imx < (v_reg[2][31] ? 32'sd0 : v_reg[2])) ? imx
                    : (v_reg[2][31] ? 32'sd0 : v_reg[2]); end
            6'd9: begin op = attm_pkg::OP_DIV; opa = spd; opb = (vs > 0) ? vs : 32'sd1; end
            6'd10: begin opa = v_reg[4]; opb = v_reg[4]; end
            6'd11: begin opa = rr; opb = rr; end
            6'd12: begin opa = attm_pkg::exp_int_q(x[19:16]);
                opb = attm_pkg::exp_frac_q(x[15:12]); end
            6'd13: begin opa = v_reg[11]; opb = poly; end
            6'd14: begin opa = stb;
                opb = (x[31] ? 32'sd65536 : ((x[30:16] >= 15'd12) ? 32'sd0 : v_reg[12])); end
            6'd15: begin op = attm_pkg::OP_ADD; opa = cou; opb = v_reg[12]; end
            6'd16: begin opa = spd[31] ? asy : 32'sd65536; opb = v_reg[12]; end
            6'd17: begin opa = vis; opb = spd; end
            6'd18: begin op = attm_pkg::OP_ADD;
                opa = spd[31] ? ((v_reg[5] == 32'sh80000000) ? 32'sh7fffffff : -v_reg[5])
                    : v_reg[5];
                opb = v_reg[6]; end
            6'd19: begin opa = cur; opb = cur; end
            6'd20: begin opa = v_reg[7]; opb = res; end
            6'd21: begin op = attm_pkg::OP_SUB; opa = temp_reg; opb = amb; end
            6'd22: begin opa = cnd; opb = v_reg[9]; end
            6'd23: begin op = attm_pkg::OP_SUB; opa = v_reg[7]; opb = v_reg[9]; end
            6'd24: begin opa = v_reg[7]; opb = $signed({1'b0, dt}); end
            6'd25: begin op = attm_pkg::OP_DIV; opa = v_reg[7];
                opb = (mass > 0) ? mass : 32'sd1; end
            6'd26: begin op = attm_pkg::OP_ADD; opa = temp_reg; opb = v_reg[7]; last = 1'b1; end
            default: begin op = attm_pkg::OP_ADD; last = 1'b1; end
        endcase
    end

    // Where each step result lands.
    always_comb begin
        wr_val = rsp.y;
        case (step_reg)
            6'd0, 6'd1, 6'd2: wr_idx = 4'd0;
            6'd3: wr_idx = 4'd1;
            6'd4, 6'd5, 6'd6, 6'd7: wr_idx = 4'd2;
            6'd8: begin wr_idx = 4'd3; wr_val = rsp.y[31] ? 32'sd0 : rsp.y; end
            6'd9: wr_idx = 4'd4;
            6'd10: wr_idx = 4'd8;
            6'd11: wr_idx = 4'd10;
            6'd12: wr_idx = 4'd11;
            6'd13, 6'd14, 6'd15, 6'd16: wr_idx = 4'd12;
            6'd17: wr_idx = 4'd6;
            6'd18: wr_idx = 4'd13;
            6'd19, 6'd20: wr_idx = 4'd7;
            6'd21: wr_idx = 4'd9;
            6'd22: wr_idx = 4'd9;
            6'd23, 6'd24, 6'd25: wr_idx = 4'd7;
            default: wr_idx = 4'd15;
        endcase
        if (step_reg == 6'd16) begin
            wr_idx = 4'd5;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next = step_reg;
        temp_next = temp_reg;
        case (state_reg)
            ST_IDLE: begin
                if (go) begin
                    state_next = ST_ISSUE;
                    step_next = 6'd0;
                end
            end
            ST_ISSUE: state_next = ST_WAIT;
            ST_WAIT: begin
                if (rsp.done) begin
                    if (last) begin
                        temp_next = rsp.y;
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_ISSUE;
                        step_next = step_reg + 6'd1;
                        if (step_reg == 6'd8 && spd == 32'sd0) begin
                            step_next = 6'd19;
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg <= '0;
            temp_reg <= attm_pkg::TempReset;
        end else begin
            state_reg <= state_next;
            step_reg <= step_next;
            temp_reg <= temp_next;
        end
        if (state_reg == ST_IDLE && go) begin
            v_reg[13] <= '0;
        end else if (state_reg == ST_WAIT && rsp.done) begin
            v_reg[wr_idx] <= wr_val;
        end
    end

    logic signed [31:0] ceil, t0, afr;
    logic signed [32:0] td;
    always_comb begin
        ceil = v_reg[3];
        t0 = (cmd > ceil) ? ceil : ((cmd < -ceil) ? -ceil : cmd);
        afr = v_reg[13][31] ? ((v_reg[13] == 32'sh80000000) ? 32'sh7fffffff : -v_reg[13])
            : v_reg[13];
        o_t = t0;
        if (!spd[31] && spd != 32'sd0) begin
            td = 33'(t0) - 33'(afr);
            o_t = td[32] ? 32'sd0 : td[31:0];
        end else if (spd[31]) begin
            td = 33'(t0) + 33'(afr);
            o_t = (!td[32] && td != 33'sd0) ? 32'sd0 : attm_pkg::sat32(66'(td));
        end else begin
            td = '0;
        end
    end

    assign req.start = (state_reg == ST_ISSUE);
    assign req.op = op;
    assign req.a = opa;
    assign req.b = opb;
    assign fin = (state_reg == ST_WAIT) && rsp.done && last;
    assign o_ceil = ceil[30:0];
    assign o_fr = v_reg[13];
    assign o_temp = rsp.y;
endmodule
`default_nettype wire

[rtl/actuator_torque_thermal_model.sv]
`default_nettype none
// One request at a time: a sequencer runs up to 27 operations on a shared Q16.16 unit
// (fewer at zero speed, where the friction steps are skipped). The result sits in an output
// register; the input is ready again once that register has been emptied.
module actuator_torque_thermal_model (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic cfg_valid,
    output logic cfg_ready,
    input wire logic [2:0] cfg_index,
    input wire logic [63:0] cfg_data,
    input wire logic s_valid,
    output logic s_ready,
    input wire logic signed [31:0] s_commanded_torque,
    input wire logic signed [31:0] s_joint_speed,
    input wire logic signed [31:0] s_winding_current,
    input wire logic [30:0] s_time_step,
    input wire logic signed [31:0] s_ambient_temp,
    output logic m_valid,
    input wire logic m_ready,
    output logic signed [31:0] m_achieved_torque,
    output logic [30:0] m_torque_ceiling,
    output logic signed [31:0] m_friction_torque,
    output logic signed [31:0] m_winding_temp_out
);
    logic [63:0] regs_reg [attm_pkg::NumRegs];
    logic busy_reg;
    logic signed [31:0] cmd_reg, spd_reg, cur_reg, amb_reg;
    logic [30:0] dt_reg;
    attm_pkg::attm_req_t req;
    attm_pkg::attm_rsp_t rsp;
    logic fin;
    logic signed [31:0] o_t, o_fr, o_temp;
    logic [30:0] o_ceil;
    logic go;

    assign cfg_ready = 1'b1;
    assign s_ready = !busy_reg && !m_valid;
    assign go = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < attm_pkg::NumRegs; i++) begin
                regs_reg[i] <= '0;
            end
            busy_reg <= 1'b0;
            m_valid <= 1'b0;
        end else begin
            if (cfg_valid && cfg_index < 3'(attm_pkg::NumRegs)) begin
                regs_reg[cfg_index] <= cfg_data;
            end
            if (go) begin
                busy_reg <= 1'b1;
            end else if (fin) begin
                busy_reg <= 1'b0;
            end
            if (fin) begin
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
        end
        if (go) begin
            cmd_reg <= s_commanded_torque;
            spd_reg <= s_joint_speed;
            cur_reg <= s_winding_current;
            dt_reg <= s_time_step;
            amb_reg <= s_ambient_temp;
        end
        if (fin) begin
            m_achieved_torque <= o_t;
            m_torque_ceiling <= o_ceil;
            m_friction_torque <= o_fr;
            m_winding_temp_out <= o_temp;
        end
    end

    attm_alu u_alu (.aclk(aclk), .aresetn(aresetn), .req(req), .rsp(rsp));

    attm_seq u_seq (
        .aclk(aclk), .aresetn(aresetn), .go(go), .regs(regs_reg),
        .cmd(cmd_reg), .spd(spd_reg), .cur(cur_reg), .dt(dt_reg), .amb(amb_reg),
        .req(req), .rsp(rsp), .fin(fin),
        .o_t(o_t), .o_ceil(o_ceil), .o_fr(o_fr), .o_temp(o_temp)
    );
endmodule
`default_nettype wire

[rtl/attm_checker.sv]
`default_nettype none
`include "actuator_torque_thermal_model_macros.svh"
module attm_checker (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_valid,
    input wire logic s_ready,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire logic [30:0] m_torque_ceiling,
    input wire logic signed [31:0] m_achieved_torque
);
    `ATTM_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    `ATTM_ASSERT_IMPL(a_no_accept_while_out, aclk, aresetn, m_valid, !s_ready)
    `ATTM_ASSERT_NEXT(a_out_holds, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_achieved_torque))
    `ATTM_ASSERT_IMPL(a_within_ceiling, aclk, aresetn, m_valid,
        $signed(m_achieved_torque) <= $signed({1'b0, m_torque_ceiling}))
endmodule

bind actuator_torque_thermal_model attm_checker u_attm_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_torque_ceiling(m_torque_ceiling),
    .m_achieved_torque(m_achieved_torque)
);
`default_nettype wire
